[rtl/go_back_n_sender_slow_start_assert.svh]
`ifndef GO_BACK_N_SENDER_SLOW_START_ASSERT_SVH
`define GO_BACK_N_SENDER_SLOW_START_ASSERT_SVH

// Condition that must hold at every edge out of reset.
`define GBSS_ASSERT_ALWAYS(name, clk_s, rst_s, cond) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) \
    else $error("gbss check failed");

// Condition that must hold in the cycle after the trigger.
`define GBSS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("gbss check failed");

`endif

[rtl/gbss_pkg.sv]
package gbss_pkg;

    // classified input operations
    localparam logic [1:0] OP_SUBMIT_DATA = 2'd0;
    localparam logic [1:0] OP_SUBMIT_FIN  = 2'd1;
    localparam logic [1:0] OP_ACK         = 2'd2;
    localparam logic [1:0] OP_ACK_DUP     = 2'd3;

    // result kinds
    localparam logic [2:0] RK_DATA   = 3'd0;
    localparam logic [2:0] RK_FIN    = 3'd1;
    localparam logic [2:0] RK_ROUND  = 3'd2;
    localparam logic [2:0] RK_DONE   = 3'd3;
    localparam logic [2:0] RK_REJECT = 3'd4;

    // sender phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_ROUND   = 2'd1;
    localparam logic [1:0] PH_FINWAIT = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    // configuration register indexes
    localparam logic REG_INIT_THRESHOLD = 1'b0;
    localparam logic REG_FIRST_SEQUENCE = 1'b1;

    localparam logic [5:0]  RST_THRESHOLD = 6'd16;
    localparam logic [31:0] RST_FIRST_SEQ = 32'd1;

    typedef struct packed {
        logic [1:0]  op;
        logic [12:0] len;
        logic [31:0] ack;
    } cmd_t;

    typedef struct packed {
        logic [31:0] seq;
        logic [12:0] len;
        logic        resent;
    } desc_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] seq;
        logic [12:0] len;
        logic        resend;
        logic [5:0]  win;
        logic [5:0]  thr;
        logic        loss;
        logic        last;
    } res_t;

endpackage

[rtl/gbss_ram.sv]
module gbss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

[rtl/gbss_front.sv]
module gbss_front import gbss_pkg::*; #(
    parameter int MAX_PAYLOAD = 5000
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        kind,
    input  logic [12:0] seg_length,
    input  logic        is_fin,
    input  logic [31:0] ack_number,
    input  logic        timed_out,
    input  logic        is_finack,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_pop
);

    localparam logic [12:0] LEN_CAP = (MAX_PAYLOAD > 8191) ? 13'h1FFF : 13'(MAX_PAYLOAD);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       cmd_in;
    logic       wr_en;
    logic       rd_en;

    // clamp the length and classify the item
    always_comb
    begin
        cmd_in.len = (seg_length > LEN_CAP) ? LEN_CAP : seg_length;
        cmd_in.ack = ack_number;
        if (!kind)
        begin
            cmd_in.op = is_fin ? OP_SUBMIT_FIN : OP_SUBMIT_DATA;
        end
        else
        begin
            cmd_in.op = (timed_out || is_finack) ? OP_ACK_DUP : OP_ACK;
        end
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_pop && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule

[rtl/gbss_outq.sv]
module gbss_outq import gbss_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic res_valid,
    input  res_t res,
    output logic res_ready,
    output logic empty,
    output res_t head,
    input  logic pop
);

    res_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       wr_en;
    logic       rd_en;

    assign res_ready = (cnt_reg != 2'd2);
    assign empty     = (cnt_reg == 2'd0);
    assign head      = slot_reg[rd_ptr_reg];
    assign wr_en     = res_valid && res_ready;
    assign rd_en     = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule

[rtl/gbss_back.sv]
module gbss_back import gbss_pkg::*; #(
    parameter int QUEUE_DEPTH = 64,
    parameter int WINDOW_MAX  = 32,
    localparam int AW  = $clog2(QUEUE_DEPTH),
    localparam int AW1 = AW + 1,
    localparam int CW  = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    output logic        res_valid,
    output res_t        res,
    input  logic        res_ready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_SEND  = 3'd2;
    localparam logic [2:0] S_CLOSE = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_ENQ   = 3'd5;

    localparam logic [AW:0]   DEPTH_X = AW1'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic [2:0]    st_reg, st_next;
    logic [1:0]    phase_reg, phase_next;
    logic [31:0]   next_seq_reg, next_seq_next;
    logic [5:0]    cwnd_reg, cwnd_next;
    logic [5:0]    thr_reg, thr_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [5:0]    rsize_reg, rsize_next;
    logic [5:0]    events_reg, events_next;
    logic [31:0]   exp_reg, exp_next;
    logic [CW-1:0] acked_reg, acked_next;
    logic          dup_reg, dup_next;
    logic          pend_reg, pend_next;
    logic [31:0]   pseq_reg, pseq_next;
    logic [12:0]   plen_reg, plen_next;
    logic          drain_reg, drain_next;
    logic [31:0]   fseq_reg, fseq_next;
    logic [5:0]    bidx_reg, bidx_next;
    logic [AW-1:0] addr_reg, addr_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    desc_t         ram_wdata;
    logic          ram_re;
    desc_t         ram_rdata;

    logic [AW:0]   rd_sum, enq_sum, rm_sum;
    logic [AW-1:0] rd_idx, enq_idx, rm_idx;
    logic [CW-1:0] removed;
    logic [6:0]    grow;
    logic [5:0]    cwnd_grow, half, thr_loss;
    logic          nodup, ack_eq, ack_gt, close;
    logic [32:0]   step;
    logic [33:0]   ev_jump, ac_jump;
    logic [5:0]    ev_new, burst_sz;
    logic [CW-1:0] ac_new;

    gbss_ram #(.WIDTH($bits(desc_t)), .DEPTH(QUEUE_DEPTH)) u_desc (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    // circular queue addressing
    always_comb
    begin
        rd_sum  = AW1'(head_reg) + AW1'(bidx_reg);
        rd_idx  = (rd_sum >= DEPTH_X) ? AW'(rd_sum - DEPTH_X) : AW'(rd_sum);
        enq_sum = AW1'(head_reg) + AW1'(count_reg);
        enq_idx = (enq_sum >= DEPTH_X) ? AW'(enq_sum - DEPTH_X) : AW'(enq_sum);
        removed = (acked_reg < count_reg) ? acked_reg : count_reg;
        rm_sum  = AW1'(head_reg) + AW1'(removed);
        rm_idx  = (rm_sum >= DEPTH_X) ? AW'(rm_sum - DEPTH_X) : AW'(rm_sum);
    end

    // window update at the end of a round
    always_comb
    begin
        grow      = (cwnd_reg < thr_reg) ? {cwnd_reg, 1'b0} : ({1'b0, cwnd_reg} + 7'd1);
        cwnd_grow = (grow > 7'(WINDOW_MAX)) ? 6'(WINDOW_MAX) : grow[5:0];
        half      = {1'b0, cwnd_reg[5:1]};
        thr_loss  = (half == 6'd0) ? 6'd1 : half;
        burst_sz  = (32'(cwnd_reg) < 32'(count_reg)) ? cwnd_reg : 6'(count_reg);
    end

    // ack classification against the expected number
    always_comb
    begin
        nodup   = !dup_reg && (cmd.op == OP_ACK);
        ack_eq  = (cmd.ack == exp_reg);
        ack_gt  = (cmd.ack > exp_reg);
        step    = {1'b0, cmd.ack - exp_reg} + 33'd1;
        ev_jump = 34'(events_reg) + 34'(step);
        ac_jump = 34'(acked_reg) + 34'(step);
        if (nodup && ack_eq)
        begin
            ev_new = events_reg + 6'd1;
            ac_new = (acked_reg == DEPTH_C) ? acked_reg : acked_reg + CW'(1);
        end
        else if (nodup && ack_gt)
        begin
            ev_new = (ev_jump > 34'(rsize_reg)) ? rsize_reg : ev_jump[5:0];
            ac_new = (ac_jump > 34'(QUEUE_DEPTH)) ? DEPTH_C : ac_jump[CW-1:0];
        end
        else
        begin
            ev_new = events_reg + 6'd1;
            ac_new = acked_reg;
        end
        close = (ev_new >= rsize_reg);
    end

    always_comb
    begin
        st_next       = st_reg;
        phase_next    = phase_reg;
        next_seq_next = next_seq_reg;
        cwnd_next     = cwnd_reg;
        thr_next      = thr_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        rsize_next    = rsize_reg;
        events_next   = events_reg;
        exp_next      = exp_reg;
        acked_next    = acked_reg;
        dup_next      = dup_reg;
        pend_next     = pend_reg;
        pseq_next     = pseq_reg;
        plen_next     = plen_reg;
        drain_next    = drain_reg;
        fseq_next     = fseq_reg;
        bidx_next     = bidx_reg;
        addr_next     = addr_reg;
        cmd_pop       = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = enq_idx;
        ram_wdata     = '{seq: next_seq_reg, len: cmd.len, resent: 1'b0};
        ram_re        = 1'b0;
        res_valid     = 1'b0;
        res           = '{kind: RK_REJECT, seq: 32'd0, len: 13'd0, resend: 1'b0,
                          win: cwnd_reg, thr: thr_reg, loss: 1'b0, last: 1'b1};

        if (cfg_we)
        begin
            if (cfg_index == REG_INIT_THRESHOLD)
            begin
                thr_next = cfg_data[5:0];
            end
            else
            begin
                next_seq_next = cfg_data;
            end
        end

        unique case (st_reg)
            S_IDLE:
            begin
                if (cmd_valid && res_ready)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.op == OP_SUBMIT_DATA || cmd.op == OP_SUBMIT_FIN)
                    begin
                        if (phase_reg != PH_IDLE
                            || (cmd.op == OP_SUBMIT_DATA && count_reg >= DEPTH_C))
                        begin
                            res_valid = 1'b1;
                        end
                        else
                        begin
                            next_seq_next = next_seq_reg + 32'd1;
                            if (cmd.op == OP_SUBMIT_FIN)
                            begin
                                fseq_next  = next_seq_reg;
                                pseq_next  = next_seq_reg;
                                plen_next  = cmd.len;
                                pend_next  = 1'b1;
                                drain_next = 1'b1;
                                st_next    = S_DRAIN;
                            end
                            else if (32'(count_reg) >= 32'(cwnd_reg))
                            begin
                                pseq_next   = next_seq_reg;
                                plen_next   = cmd.len;
                                pend_next   = 1'b1;
                                rsize_next  = cwnd_reg;
                                bidx_next   = 6'd0;
                                phase_next  = PH_ROUND;
                                events_next = 6'd0;
                                acked_next  = '0;
                                dup_next    = 1'b0;
                                st_next     = S_RD;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                    end
                    else if (phase_reg == PH_ROUND)
                    begin
                        events_next = ev_new;
                        acked_next  = ac_new;
                        if (nodup && ack_eq)
                        begin
                            exp_next = exp_reg + 32'd1;
                        end
                        else if (nodup && ack_gt)
                        begin
                            exp_next = cmd.ack + 32'd1;
                        end
                        else
                        begin
                            dup_next = 1'b1;
                        end
                        if (close)
                        begin
                            st_next = S_CLOSE;
                        end
                    end
                    else if (phase_reg == PH_FINWAIT)
                    begin
                        phase_next = PH_DONE;
                        res_valid  = 1'b1;
                        res.kind   = RK_DONE;
                    end
                end
            end

            S_RD:
            begin
                ram_re    = 1'b1;
                addr_next = rd_idx;
                st_next   = S_SEND;
            end

            S_SEND:
            begin
                if (res_ready)
                begin
                    res_valid  = 1'b1;
                    res.kind   = RK_DATA;
                    res.seq    = ram_rdata.seq;
                    res.len    = ram_rdata.len;
                    res.resend = ram_rdata.resent;
                    res.last   = (bidx_reg == rsize_reg - 6'd1);
                    ram_we     = 1'b1;
                    ram_waddr  = addr_reg;
                    ram_wdata  = '{seq: ram_rdata.seq, len: ram_rdata.len, resent: 1'b1};
                    if (bidx_reg == 6'd0)
                    begin
                        exp_next = ram_rdata.seq;
                    end
                    bidx_next = bidx_reg + 6'd1;
                    st_next   = res.last ? S_IDLE : S_RD;
                end
            end

            S_CLOSE:
            begin
                if (res_ready)
                begin
                    head_next  = rm_idx;
                    count_next = count_reg - removed;
                    if (dup_reg)
                    begin
                        thr_next  = thr_loss;
                        cwnd_next = 6'd1;
                    end
                    else
                    begin
                        cwnd_next = cwnd_grow;
                    end
                    res_valid  = 1'b1;
                    res.kind   = RK_ROUND;
                    res.win    = cwnd_next;
                    res.thr    = thr_next;
                    res.loss   = dup_reg;
                    res.last   = !drain_reg;
                    phase_next = PH_IDLE;
                    if (drain_reg)
                    begin
                        st_next = S_DRAIN;
                    end
                    else if (pend_reg)
                    begin
                        st_next = S_ENQ;
                    end
                    else
                    begin
                        st_next = S_IDLE;
                    end
                end
            end

            S_DRAIN:
            begin
                if (count_reg != '0)
                begin
                    rsize_next  = burst_sz;
                    bidx_next   = 6'd0;
                    phase_next  = PH_ROUND;
                    events_next = 6'd0;
                    acked_next  = '0;
                    dup_next    = 1'b0;
                    st_next     = S_RD;
                end
                else if (res_ready)
                begin
                    res_valid  = 1'b1;
                    res.kind   = RK_FIN;
                    res.seq    = fseq_reg;
                    res.len    = plen_reg;
                    drain_next = 1'b0;
                    pend_next  = 1'b0;
                    phase_next = PH_FINWAIT;
                    st_next    = S_IDLE;
                end
            end

            S_ENQ:
            begin
                if (count_reg < DEPTH_C)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = '{seq: pseq_reg, len: plen_reg, resent: 1'b0};
                    count_next = count_reg + CW'(1);
                end
                pend_next = 1'b0;
                st_next   = S_IDLE;
            end

            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= S_IDLE;
            phase_reg    <= PH_IDLE;
            next_seq_reg <= RST_FIRST_SEQ;
            cwnd_reg     <= 6'd1;
            thr_reg      <= RST_THRESHOLD;
            head_reg     <= '0;
            count_reg    <= '0;
            rsize_reg    <= 6'd0;
            events_reg   <= 6'd0;
            acked_reg    <= '0;
            dup_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            drain_reg    <= 1'b0;
            bidx_reg     <= 6'd0;
        end
        else
        begin
            st_reg       <= st_next;
            phase_reg    <= phase_next;
            next_seq_reg <= next_seq_next;
            cwnd_reg     <= cwnd_next;
            thr_reg      <= thr_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            rsize_reg    <= rsize_next;
            events_reg   <= events_next;
            acked_reg    <= acked_next;
            dup_reg      <= dup_next;
            pend_reg     <= pend_next;
            drain_reg    <= drain_next;
            bidx_reg     <= bidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg  <= exp_next;
        pseq_reg <= pseq_next;
        plen_reg <= plen_next;
        fseq_reg <= fseq_next;
        addr_reg <= addr_next;
    end

endmodule

[rtl/go_back_n_sender_slow_start.sv]
// Channel   Handshake              Fields
// input     push / full            kind seg_length is_fin ack_number timed_out is_finack
// result    empty / pop            result_kind seq_number out_length is_resend
//                                  window_size threshold_now loss_seen last
// config    cfg_we                 cfg_index cfg_data
//
// A submit that only queues, a reject, a mid-round ack and a finish are handled in the sequencer's
// S_IDLE state; each transmit of a burst visits S_RD (descriptor RAM read), then S_SEND.
// Closing a round passes through S_CLOSE, then S_ENQ to requeue a held segment.
// Reset (rst_n, async) empties both queues and loads threshold 16, first sequence 1.
// Input and result sides stall independently through a two-item queue each.
module go_back_n_sender_slow_start import gbss_pkg::*; #(
    parameter int QUEUE_DEPTH = 64,
    parameter int WINDOW_MAX  = 32,
    parameter int MAX_PAYLOAD = 5000
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        kind,
    input  logic [12:0] seg_length,
    input  logic        is_fin,
    input  logic [31:0] ack_number,
    input  logic        timed_out,
    input  logic        is_finack,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  result_kind,
    output logic [31:0] seq_number,
    output logic [12:0] out_length,
    output logic        is_resend,
    output logic [5:0]  window_size,
    output logic [5:0]  threshold_now,
    output logic        loss_seen,
    output logic        last
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;
    res_t res;
    logic res_valid;
    logic res_ready;
    res_t head;

    // accept and classify incoming items
    gbss_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .seg_length (seg_length),
        .is_fin     (is_fin),
        .ack_number (ack_number),
        .timed_out  (timed_out),
        .is_finack  (is_finack),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    // sequence rounds, bursts and window updates
    gbss_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .WINDOW_MAX(WINDOW_MAX)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // hold results until the consumer pops them
    gbss_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .empty     (empty),
        .head      (head),
        .pop       (pop)
    );

    assign result_kind   = head.kind;
    assign seq_number    = head.seq;
    assign out_length    = head.len;
    assign is_resend     = head.resend;
    assign window_size   = head.win;
    assign threshold_now = head.thr;
    assign loss_seen     = head.loss;
    assign last          = head.last;

endmodule

[rtl/gbss_checker.sv]
`include "go_back_n_sender_slow_start_assert.svh"

module gbss_checker import gbss_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  result_kind,
    input logic [31:0] seq_number,
    input logic [5:0]  window_size,
    input logic        loss_seen
);

    // a waiting result holds until taken
    `GBSS_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(seq_number) && $stable(result_kind))
    `GBSS_ASSERT_ALWAYS(a_kind, clk, rst_n, empty || result_kind <= RK_REJECT)
    `GBSS_ASSERT_ALWAYS(a_window, clk, rst_n, empty || window_size != 6'd0)
    `GBSS_ASSERT_ALWAYS(a_loss, clk, rst_n, empty || result_kind == RK_ROUND || !loss_seen)

endmodule

bind go_back_n_sender_slow_start gbss_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .result_kind (result_kind),
    .seq_number  (seq_number),
    .window_size (window_size),
    .loss_seen   (loss_seen)
);
